// ===== hdl/bitfc_pkg.sv =====
// bitfc_pkg: shared codes and constants for the boot id frame checker
// no dependencies; used by the channel interfaces and the top level
package bitfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ITEM_W   = 3;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned CHIP_W   = 24;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_SEARCH   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PARSE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_SYNC  = 3'd5;

    // position within one item
    localparam logic [PHASE_W-1:0] PH_ID   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDENT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECURE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PUBLIC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROOT_HASH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHECKSUMS = 3'd5;

    // items and start pattern
    localparam logic [ITEM_W-1:0] ITEM_IDENT  = 3'd0;
    localparam logic [ITEM_W-1:0] ITEM_PUBLIC = 3'd2;
    localparam logic [ITEM_W-1:0] ITEM_LAST   = 3'd4;
    localparam logic [BYTE_W-1:0] SYNC_COUNT_SHORT = 8'h04;
    localparam logic [BYTE_W-1:0] SYNC_COUNT_FULL  = 8'h05;
    localparam logic [BYTE_W-1:0] SYNC_ID          = 8'h01;
    localparam logic [BYTE_W-1:0] SYNC_LEN         = 8'h05;

    function automatic logic [BYTE_W-1:0] item_id(input logic [ITEM_W-1:0] item);
        logic [BYTE_W-1:0] id;
        case (item)
            3'd0:    id = 8'h01;
            3'd1:    id = 8'h13;
            3'd2:    id = 8'h12;
            3'd3:    id = 8'h14;
            default: id = 8'h15;
        endcase
        return id;
    endfunction

endpackage

// ===== hdl/bitfc_in_if.sv =====
// bitfc_in_if: receive byte channel of the boot id frame checker
// depends on bitfc_pkg
interface bitfc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bitfc_pkg::BYTE_W-1:0] rx_byte;
    logic                       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== hdl/bitfc_out_if.sv =====
// bitfc_out_if: per-byte result channel of the boot id frame checker
// depends on bitfc_pkg
interface bitfc_out_if;
    logic                           valid;
    logic                           ready;
    logic [bitfc_pkg::STATUS_W-1:0] status;
    logic [bitfc_pkg::ITEM_W-1:0]   item_number;
    logic [bitfc_pkg::PHASE_W-1:0]  item_phase;
    logic [bitfc_pkg::BYTE_W-1:0]   payload_offset;
    logic [bitfc_pkg::CHIP_W-1:0]   chip_id;
    logic [bitfc_pkg::BYTE_W-1:0]   chip_version;
    logic                           secure_flag;

    modport source (output valid, output status, output item_number, output item_phase,
                    output payload_offset, output chip_id, output chip_version,
                    output secure_flag, input ready);
    modport sink   (input valid, input status, input item_number, input item_phase,
                    input payload_offset, input chip_id, input chip_version,
                    input secure_flag, output ready);
endinterface

// ===== hdl/bitfc_cfg_if.sv =====
// bitfc_cfg_if: register write channel of the boot id frame checker
// depends on bitfc_pkg
interface bitfc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bitfc_pkg::CFG_IDX_W-1:0] index;
    logic [bitfc_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/boot_id_tlv_frame_checker.sv =====
// boot_id_tlv_frame_checker: hunts the start pattern, then checks the id and length
// of each type-length item and extracts chip id, version and secure flag.
// latency: a result beat is valid the cycle after its byte is accepted.
// throughput: one byte per cycle while the result side is ready; the only loop is the registered state update.
// reset (synchronous, active low) restores register defaults and clears the parse state.
// depends on bitfc_pkg, bitfc_in_if, bitfc_out_if, bitfc_cfg_if
module boot_id_tlv_frame_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bitfc_in_if.sink     i_in,
    bitfc_cfg_if.sink    i_cfg,
    bitfc_out_if.source  o_out
);
    import bitfc_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] r_search_limit;
    logic [BYTE_W-1:0] r_max_ident;
    logic [BYTE_W-1:0] r_max_secure;
    logic [BYTE_W-1:0] r_max_public;
    logic [BYTE_W-1:0] r_max_root_hash;
    logic [BYTE_W-1:0] r_max_checksums;

    // parse state
    logic [2*BYTE_W-1:0] r_window,   n_window;
    logic [POS_W-1:0]    r_pos,      n_pos;
    logic [ITEM_W-1:0]   r_left,     n_left;
    logic [ITEM_W-1:0]   r_item,     n_item;
    logic [PHASE_W-1:0]  r_phase,    n_phase;
    logic [BYTE_W-1:0]   r_remain,   n_remain;
    logic [STATUS_W-1:0] r_status,   n_status;
    logic [CHIP_W-1:0]   r_chip_id,  n_chip_id;
    logic [BYTE_W-1:0]   r_version,  n_version;
    logic                r_secure,   n_secure;
    logic [BYTE_W-1:0]   r_count,    n_count;

    // result register
    logic                r_out_valid;
    logic [ITEM_W-1:0]   r_out_num,  n_out_num;
    logic [PHASE_W-1:0]  r_out_ph,   n_out_ph;
    logic [BYTE_W-1:0]   r_out_off,  n_out_off;

    logic                in_beat;
    logic                do_finish;
    logic [BYTE_W-1:0]   max_len;
    logic [ITEM_W-1:0]   item_sat;
    logic [BYTE_W-1:0]   b;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_beat     = i_in.valid && i_in.ready;
    assign b           = i_in.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_limit  <= 8'd32;
            r_max_ident     <= 8'd7;
            r_max_secure    <= 8'd4;
            r_max_public    <= 8'd23;
            r_max_root_hash <= 8'd35;
            r_max_checksums <= 8'd11;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEARCH_LIMIT:  r_search_limit  <= i_cfg.data;
                CFG_MAX_IDENT:     r_max_ident     <= i_cfg.data;
                CFG_MAX_SECURE:    r_max_secure    <= i_cfg.data;
                CFG_MAX_PUBLIC:    r_max_public    <= i_cfg.data;
                CFG_MAX_ROOT_HASH: r_max_root_hash <= i_cfg.data;
                CFG_MAX_CHECKSUMS: r_max_checksums <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // frame_start wipes the state before this byte is looked at
        if (i_in.frame_start) begin
            n_window  = '0;
            n_pos     = '0;
            n_left    = '0;
            n_item    = '0;
            n_phase   = PH_ID;
            n_remain  = '0;
            n_status  = ST_SEARCH;
            n_chip_id = '0;
            n_version = '0;
            n_secure  = 1'b0;
            n_count   = '0;
        end else begin
            n_window  = r_window;
            n_pos     = r_pos;
            n_left    = r_left;
            n_item    = r_item;
            n_phase   = r_phase;
            n_remain  = r_remain;
            n_status  = r_status;
            n_chip_id = r_chip_id;
            n_version = r_version;
            n_secure  = r_secure;
            n_count   = r_count;
        end

        n_out_num = '0;
        n_out_ph  = PH_ID;
        n_out_off = '0;
        do_finish = 1'b0;
        item_sat  = (n_item < ITEM_LAST) ? n_item : ITEM_LAST;

        case (item_sat)
            3'd0:    max_len = r_max_ident;
            3'd1:    max_len = r_max_secure;
            3'd2:    max_len = r_max_public;
            3'd3:    max_len = r_max_root_hash;
            default: max_len = r_max_checksums;
        endcase

        case (n_status)
            ST_SEARCH: begin
                if (n_pos >= 9'd2
                    && (n_window[15:8] == SYNC_COUNT_SHORT
                        || n_window[15:8] == SYNC_COUNT_FULL)
                    && n_window[7:0] == SYNC_ID && b == SYNC_LEN) begin
                    // sync byte doubles as the length byte of the first item
                    n_status = ST_PARSE;
                    n_left   = n_window[ITEM_W-1+8:8];
                    n_item   = ITEM_IDENT;
                    n_phase  = PH_LEN;
                    n_out_ph = PH_LEN;
                    if (SYNC_LEN > r_max_ident) begin
                        n_status = ST_TOO_LONG;
                    end else begin
                        n_remain = SYNC_LEN;
                        n_count  = '0;
                        n_phase  = PH_DATA;
                    end
                end else if (n_pos >= {1'b0, r_search_limit} + 9'd2) begin
                    n_status = ST_NO_SYNC;
                end else begin
                    n_window = {n_window[7:0], b};
                    n_pos    = n_pos + 9'd1;
                end
            end
            ST_PARSE: begin
                n_out_num = item_sat;
                n_out_ph  = n_phase;
                case (n_phase)
                    PH_ID: begin
                        if (b != item_id(item_sat)) begin
                            n_status = ST_BAD_ID;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_phase = PH_LEN;
                        if (b > max_len) begin
                            n_status = ST_TOO_LONG;
                        end else begin
                            n_remain = b;
                            n_count  = '0;
                            if (b == 8'd0) begin
                                do_finish = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    default: begin
                        n_out_off = n_count;
                        if (item_sat == ITEM_IDENT) begin
                            if (n_count inside {[8'd1:8'd3]}) begin
                                n_chip_id = {n_chip_id[15:0], b};
                            end else if (n_count == 8'd4) begin
                                n_version = b;
                            end
                        end else if (item_sat == ITEM_PUBLIC) begin
                            if (n_count inside {[8'd1:8'd20]} && b != 8'd0) begin
                                n_secure = 1'b1;
                            end
                        end
                        n_count  = n_count + 8'd1;
                        n_remain = n_remain - 8'd1;
                        if (n_remain == 8'd0) begin
                            do_finish = 1'b1;
                        end
                    end
                endcase
            end
            ST_NO_SYNC: ;
            default: begin
                n_out_num = n_item;
                n_out_ph  = n_phase;
            end
        endcase

        if (do_finish) begin
            n_left = n_left - 3'd1;
            if (n_left == 3'd0 || n_item >= ITEM_LAST) begin
                n_status = ST_DONE;
            end else begin
                n_item  = n_item + 3'd1;
                n_phase = PH_ID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_pos       <= '0;
            r_left      <= '0;
            r_item      <= '0;
            r_phase     <= PH_ID;
            r_remain    <= '0;
            r_status    <= ST_SEARCH;
            r_chip_id   <= '0;
            r_version   <= '0;
            r_secure    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_window  <= n_window;
                r_pos     <= n_pos;
                r_left    <= n_left;
                r_item    <= n_item;
                r_phase   <= n_phase;
                r_remain  <= n_remain;
                r_status  <= n_status;
                r_chip_id <= n_chip_id;
                r_version <= n_version;
                r_secure  <= n_secure;
                r_count   <= n_count;
            end
            if (in_beat) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted byte
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_num <= n_out_num;
            r_out_ph  <= n_out_ph;
            r_out_off <= n_out_off;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.item_number    = r_out_num;
    assign o_out.item_phase     = r_out_ph;
    assign o_out.payload_offset = r_out_off;
    assign o_out.chip_id        = r_chip_id;
    assign o_out.chip_version   = r_version;
    assign o_out.secure_flag    = r_secure;

endmodule

// ===== tb/sv/tb_boot_id_tlv_frame_checker.sv =====
// tb_boot_id_tlv_frame_checker: self-checking bench for the boot id frame checker
// predicts every result beat from its own model of sync search and item walk
// depends on bitfc_pkg, bitfc_in_if, bitfc_out_if, bitfc_cfg_if and the block
module tb_boot_id_tlv_frame_checker;
    import bitfc_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   item_number;
        logic [PHASE_W-1:0]  item_phase;
        logic [BYTE_W-1:0]   payload_offset;
        logic [CHIP_W-1:0]   chip_id;
        logic [BYTE_W-1:0]   chip_version;
        logic                secure_flag;
    } t_frame_result;

    class t_frame_scoreboard;
        logic [BYTE_W-1:0]   search_limit;
        logic [BYTE_W-1:0]   max_len [5];
        logic [BYTE_W-1:0]   item_tag [5];
        logic [15:0]         sync_win;
        logic [POS_W-1:0]    search_pos;
        logic [ITEM_W-1:0]   items_left;
        logic [ITEM_W-1:0]   cur_item;
        logic [PHASE_W-1:0]  phase;
        logic [BYTE_W-1:0]   bytes_left;
        logic [BYTE_W-1:0]   payload_cnt;
        logic [STATUS_W-1:0] status;
        logic [CHIP_W-1:0]   chip_id;
        logic [BYTE_W-1:0]   chip_ver;
        logic                secure;
        t_frame_result       expected_q[$];
        int                  errors;

        function new();
            item_tag = '{8'h01, 8'h13, 8'h12, 8'h14, 8'h15};
            errors = 0;
            restore_defaults();
        endfunction

        function void clear_frame();
            sync_win = '0;
            search_pos = '0;
            items_left = '0;
            cur_item = '0;
            phase = PH_ID;
            bytes_left = '0;
            payload_cnt = '0;
            status = ST_SEARCH;
            chip_id = '0;
            chip_ver = '0;
            secure = 1'b0;
        endfunction

        function void restore_defaults();
            search_limit = 8'd32;
            max_len = '{8'd7, 8'd4, 8'd23, 8'd35, 8'd11};
            clear_frame();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_SEARCH_LIMIT:  search_limit = val;
                CFG_MAX_IDENT:     max_len[0] = val;
                CFG_MAX_SECURE:    max_len[1] = val;
                CFG_MAX_PUBLIC:    max_len[2] = val;
                CFG_MAX_ROOT_HASH: max_len[3] = val;
                CFG_MAX_CHECKSUMS: max_len[4] = val;
                default: ;
            endcase
        endfunction

        function void finish_item();
            items_left = items_left - 1'b1;
            if (items_left == 0 || cur_item >= ITEM_LAST) begin
                status = ST_DONE;
            end else begin
                cur_item = cur_item + 1'b1;
                phase = PH_ID;
            end
        endfunction

        function void take_length(logic [BYTE_W-1:0] len);
            phase = PH_LEN;
            if (len > max_len[cur_item]) begin
                status = ST_TOO_LONG;
                return;
            end
            bytes_left = len;
            payload_cnt = '0;
            if (len == 0) begin
                finish_item();
            end else begin
                phase = PH_DATA;
            end
        endfunction

        // advance the model by one accepted byte and queue the beat it must produce
        function void note_byte(logic [BYTE_W-1:0] b, logic restart);
            t_frame_result r;
            logic [BYTE_W-1:0] off;
            r = '0;
            if (restart) clear_frame();
            if (status == ST_SEARCH) begin
                if (search_pos >= 2 && (sync_win[15:8] == SYNC_COUNT_SHORT ||
                    sync_win[15:8] == SYNC_COUNT_FULL) && sync_win[7:0] == SYNC_ID &&
                    b == SYNC_LEN) begin
                    // the closing sync byte doubles as the ident item length
                    status = ST_PARSE;
                    items_left = sync_win[ITEM_W+7:8];
                    cur_item = ITEM_IDENT;
                    take_length(b);
                    r.item_phase = PH_LEN;
                end else if (search_pos >= {1'b0, search_limit} + 9'd2) begin
                    status = ST_NO_SYNC;
                end else begin
                    sync_win = {sync_win[7:0], b};
                    search_pos = search_pos + 1'b1;
                end
            end else if (status == ST_PARSE) begin
                r.item_number = cur_item;
                r.item_phase = phase;
                if (phase == PH_ID) begin
                    if (b != item_tag[cur_item]) status = ST_BAD_ID;
                    else phase = PH_LEN;
                end else if (phase == PH_LEN) begin
                    take_length(b);
                end else begin
                    off = payload_cnt;
                    r.payload_offset = off;
                    if (cur_item == ITEM_IDENT) begin
                        if (off >= 1 && off <= 3) chip_id = {chip_id[15:0], b};
                        else if (off == 4) chip_ver = b;
                    end else if (cur_item == ITEM_PUBLIC) begin
                        if (off >= 1 && off <= 20 && b != 0) secure = 1'b1;
                    end
                    payload_cnt = payload_cnt + 1'b1;
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0) finish_item();
                end
            end else if (status != ST_NO_SYNC) begin
                r.item_number = cur_item;
                r.item_phase = phase;
            end
            r.status = status;
            r.chip_id = chip_id;
            r.chip_version = chip_ver;
            r.secure_flag = secure;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                $error("result beat with no byte pending (status %0d)", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("item_number", 32'(want.item_number), 32'(got.item_number));
            compare_field("item_phase", 32'(want.item_phase), 32'(got.item_phase));
            compare_field("payload_offset", 32'(want.payload_offset),
                          32'(got.payload_offset));
            compare_field("chip_id", 32'(want.chip_id), 32'(got.chip_id));
            compare_field("chip_version", 32'(want.chip_version),
                          32'(got.chip_version));
            compare_field("secure_flag", 32'(want.secure_flag), 32'(got.secure_flag));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bitfc_in_if  in_ch();
    bitfc_cfg_if cfg_ch();
    bitfc_out_if out_ch();

    boot_id_tlv_frame_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_frame_scoreboard sb;
    logic [BYTE_W-1:0] frame_q[$];
    bit                start_q[$];
    int                src_idle_pct;
    int                rx_stall_pct;
    int                bytes_sent;
    bit                hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_200_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit restart);
        frame_q.push_back(b);
        start_q.push_back(restart);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit restart);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.frame_start <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, restart);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], start_q[i]);
        frame_q.delete();
        start_q.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
    endtask

    // only called with the byte channel quiet and every beat returned
    task automatic write_setting(input logic [BYTE_W-1:0] limit, input logic [BYTE_W-1:0] ident,
                                 input logic [BYTE_W-1:0] sec, input logic [BYTE_W-1:0] pub,
                                 input logic [BYTE_W-1:0] root, input logic [BYTE_W-1:0] chk);
        write_reg(CFG_SEARCH_LIMIT, limit);
        write_reg(CFG_MAX_IDENT, ident);
        write_reg(CFG_MAX_SECURE, sec);
        write_reg(CFG_MAX_PUBLIC, pub);
        write_reg(CFG_MAX_ROOT_HASH, root);
        write_reg(CFG_MAX_CHECKSUMS, chk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one frame with random content: mostly well formed, some broken, some noise
    task automatic build_frame();
        int kind, n_items, prefix_len, bad_at, cap, ln, cut;
        bit broken, quiet;
        logic [BYTE_W-1:0] tag, b;
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 20))
                push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
            return;
        end
        if (kind < 12 && sb.search_limit <= 40) begin
            // junk running past the last allowed start position
            repeat (sb.search_limit + $urandom_range(3, 5))
                push_byte(8'($urandom_range(255)), frame_q.size() == 0);
            return;
        end
        n_items = $urandom_range(4, 5);
        bad_at = (kind < 30) ? $urandom_range(1, n_items - 1) : 0;
        prefix_len = $urandom_range(0, sb.search_limit < 12 ? sb.search_limit : 12);
        if ($urandom_range(7) == 0 && sb.search_limit <= 40)
            prefix_len = int'(sb.search_limit);
        repeat (prefix_len) push_byte(8'($urandom_range(255)), frame_q.size() == 0);
        push_byte(n_items == 4 ? SYNC_COUNT_SHORT : SYNC_COUNT_FULL, frame_q.size() == 0);
        push_byte(SYNC_ID, 1'b0);
        push_byte(SYNC_LEN, 1'b0);
        repeat (5) push_byte(8'($urandom_range(255)), 1'b0);
        broken = 1'b0;
        for (int k = 1; k < n_items && !broken; k++) begin
            tag = sb.item_tag[k];
            if (bad_at == k && kind < 21) begin
                tag = tag ^ 8'($urandom_range(1, 255));
                broken = 1'b1;
            end
            push_byte(tag, 1'b0);
            if (broken) break;
            if (bad_at == k && sb.max_len[k] != 8'hff) begin
                push_byte(8'($urandom_range(int'(sb.max_len[k]) + 1, 255)), 1'b0);
                broken = 1'b1;
                break;
            end
            cap = (sb.max_len[k] < 24) ? int'(sb.max_len[k]) : 24;
            ln = $urandom_range(0, cap);
            if ($urandom_range(39) == 0) ln = int'(sb.max_len[k]);
            push_byte(8'(ln), 1'b0);
            quiet = 1'($urandom_range(1));
            for (int j = 0; j < ln; j++) begin
                b = 8'($urandom_range(255));
                // public id all zero except outside the bytes that count
                if (k == ITEM_PUBLIC && quiet && j >= 1 && j <= 20) b = '0;
                push_byte(b, 1'b0);
            end
        end
        repeat ($urandom_range(broken ? 1 : 0, 3)) push_byte(8'($urandom_range(255)), 1'b0);
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            frame_q = frame_q[0:cut-1];
            start_q = start_q[0:cut-1];
        end
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int hold_left;
        t_frame_result got;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.status = out_ch.status;
                got.item_number = out_ch.item_number;
                got.item_phase = out_ch.item_phase;
                got.payload_offset = out_ch.payload_offset;
                got.chip_id = out_ch.chip_id;
                got.chip_version = out_ch.chip_version;
                got.secure_flag = out_ch.secure_flag;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_left = 200;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] seq[$];
        int target;
        bit pressure_done;
        sb = new();
        src_idle_pct = 12;
        rx_stall_pct = 83;
        bytes_sent = 0;
        hold_req = 1'b0;
        pressure_done = 1'b0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= '0;
        in_ch.frame_start <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_SEARCH_LIMIT;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shortest four-item frame straight after reset, all-ones chip data, then a held byte
        seq = '{SYNC_COUNT_SHORT, SYNC_ID, SYNC_LEN, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                8'h13, 8'h00, 8'h12, 8'h00, 8'h14, 8'h00, 8'h00};
        foreach (seq[i]) push_byte(seq[i], 1'b0);
        send_frame();
        // restart, five-item count, all-zero ident data, wrong secure mode id
        seq = '{SYNC_COUNT_FULL, SYNC_ID, SYNC_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h99};
        foreach (seq[i]) push_byte(seq[i], i == 0);
        send_frame();

        for (int seg = 0; seg < 6; seg++) begin
            src_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 83 : 0;
            rx_stall_pct = (seg < 2) ? 83 : (seg < 4) ? 12 : 0;
            in_ch.valid <= 1'b0;
            drain();
            case (seg)
                1: write_setting(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
                2: write_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                3: write_setting(8'($urandom_range(0, 40)), 8'($urandom_range(5, 8)),
                                 8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
                                 8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)));
                4: write_setting(8'd2, 8'd5, 8'd0, 8'd20, 8'd1, 8'hff);
                5: write_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: ;
            endcase
            target = bytes_sent + 150;
            while (bytes_sent < target) begin
                if (seg == 4 && !pressure_done && bytes_sent > target - 100) begin
                    hold_req = 1'b1;
                    pressure_done = 1'b1;
                end
                build_frame();
                send_frame();
            end
        end

        in_ch.valid <= 1'b0;
        drain();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
